@@ rtl/core/adsr_pkg.sv @@
package adsr_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned StepW  = 20;
  localparam int unsigned GainW  = 16;
  localparam int unsigned QuotW  = 16;
  localparam int unsigned DivW   = TimeW + 1;

  localparam logic [StepW-1:0] TIME_STEP_RESET = 20'd1486;

  localparam logic [2:0] PH_ATTACK  = 3'd0;
  localparam logic [2:0] PH_DECAY   = 3'd1;
  localparam logic [2:0] PH_SUSTAIN = 3'd2;
  localparam logic [2:0] PH_RELEASE = 3'd3;
  localparam logic [2:0] PH_IDLE    = 3'd4;

  typedef struct packed {
    logic                    gate_on;
    logic [TimeW-1:0]        attack_time;
    logic [TimeW-1:0]        decay_time;
    logic signed [GainW-1:0] sustain_level;
    logic [TimeW-1:0]        release_time;
    logic                    stream_end;
  } adsr_in_t;

  typedef struct packed {
    logic signed [GainW-1:0] gain;
    logic [2:0]              phase;
  } adsr_out_t;

  typedef struct packed {
    logic            start;
    logic [DivW-1:0] num;
    logic [DivW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QuotW-1:0] quot;
  } div_rsp_t;

endpackage

@@ rtl/core/adsr_divider.sv @@
module adsr_divider
  import adsr_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int unsigned RemW = DivW + 1;
  localparam int unsigned CntW = $clog2(QuotW);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [RemW-1:0] rem_q, rem_d;
  logic [DivW-1:0] den_q, den_d;
  logic [QuotW-1:0] quot_q, quot_d;
  logic [RemW-1:0] shifted;
  logic            ge;

  // First step compares the numerator as is; it yields the integer bit.
  assign shifted = (cnt_q == '0) ? rem_q : {rem_q[RemW-2:0], 1'b0};
  assign ge      = shifted >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quot_d = quot_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = {1'b0, req_i.num};
      den_d  = req_i.den;
      quot_d = '0;
    end else if (busy_q) begin
      rem_d  = ge ? (shifted - {1'b0, den_q}) : shifted;
      quot_d = {quot_q[QuotW-2:0], ge};
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == CntW'(QuotW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    quot_q <= quot_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

@@ rtl/core/adsr_envelope_generator_unit.sv @@
// ADSR envelope generator: one input transaction per audio sample carries the
// gate, the attack, decay and release times (unsigned Q16.16 ms) and the
// sustain level (signed Q1.15); it returns one gain (signed Q1.15, -32768 is
// silence) and the phase code that produced it. A transaction with stream_end
// set is consumed without a result and leaves the phase time and last gate
// alone. The time step register (Q4.16 ms per sample, reset 1486) is written
// through cfg_we_i / cfg_wdata_i; the user must write it only while the block
// is idle, which the block does not enforce. A sample in attack, decay or
// release passes through phase selection, the bit-per-cycle restoring divider
// that forms the phase ratio (16 quotient steps, then the quotient register),
// squaring, scaling, and rounding and loading of the output register. A
// sustain or idle sample skips the arithmetic. in_stall_o is high while a
// sample is in work, so the next sample is taken at the earliest in the
// cycle after the result is loaded; a finished result waits in the output
// register without blocking the next sample, and a result still stalled
// there only holds the final step of the one after it.
module adsr_envelope_generator_unit
  import adsr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  adsr_in_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output adsr_out_t        out_data_o,
  input  logic             cfg_we_i,
  input  logic [StepW-1:0] cfg_wdata_i
);

  localparam int unsigned CoefW = 17;
  localparam int unsigned SqW   = 2 * QuotW - 1;
  localparam int unsigned ProdW = CoefW + SqW;
  localparam int unsigned RndW  = ProdW - 30;
  localparam int unsigned SumW  = GainW + 3;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_DECIDE = 6'b000010,
    ST_DIV    = 6'b000100,
    ST_SQR    = 6'b001000,
    ST_MUL    = 6'b010000,
    ST_FINISH = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [StepW-1:0] time_step_q;
  logic [TimeW-1:0] phase_time_q;
  logic             prev_gate_q;

  // latched sample
  logic                    gate_q;
  logic [TimeW-1:0]        a_q, d_q, r_q, t_q;
  logic signed [GainW-1:0] s_q;

  logic [2:0]              phase_q;
  logic signed [GainW-1:0] base_q;
  logic [CoefW-1:0]        coef_q;
  logic [QuotW-1:0]        quot_q;
  logic [SqW-1:0]          sq_q;
  logic [ProdW-1:0]        prod_q;

  logic      out_valid_q;
  adsr_out_t out_data_q;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic in_accept, out_free;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // phase selection on the latched sample; the decay bound is taken at 33 bits
  logic [DivW-1:0] t_ext, ad_sum;
  logic            in_attack, in_decay, in_release, timed;
  assign t_ext      = {1'b0, t_q};
  assign ad_sum     = {1'b0, a_q} + {1'b0, d_q};
  assign in_attack  = gate_q && (a_q != '0) && (t_q <= a_q);
  assign in_decay   = gate_q && !in_attack && (d_q != '0) && (t_ext <= ad_sum);
  assign in_release = !gate_q && (r_q != '0) && (t_q <= r_q);
  assign timed      = in_attack || in_decay || in_release;

  always_comb begin
    div_req.start = (state_q == ST_DECIDE) && timed;
    div_req.num   = t_ext;
    div_req.den   = {1'b0, a_q};
    if (in_decay) begin
      div_req.num = ad_sum - t_ext;
      div_req.den = {1'b0, d_q};
    end else if (in_release) begin
      div_req.num = {1'b0, r_q - t_q};
      div_req.den = {1'b0, r_q};
    end
  end

  adsr_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // saturating time advance
  logic [TimeW:0]   t_sum;
  logic [TimeW-1:0] t_next;
  assign t_sum  = {1'b0, t_q} + {{(TimeW + 1 - StepW){1'b0}}, time_step_q};
  assign t_next = t_sum[TimeW] ? '1 : t_sum[TimeW-1:0];

  // round the Q30 scaled square, add the phase offset, clamp
  logic [ProdW-1:0]        prod_rnd;
  logic [RndW-1:0]         rnd;
  logic signed [SumW-1:0]  gain_sum;
  logic signed [GainW-1:0] gain_sat;
  assign prod_rnd = prod_q + ProdW'(64'd1 << 29);
  assign rnd      = prod_rnd[ProdW-1:30];
  assign gain_sum = $signed({{(SumW - RndW){1'b0}}, rnd})
                  + {{(SumW - GainW){base_q[GainW-1]}}, base_q};
  always_comb begin
    if (gain_sum > SumW'(32767)) begin
      gain_sat = 16'sh7FFF;
    end else if (gain_sum < -SumW'(32768)) begin
      gain_sat = 16'sh8000;
    end else begin
      gain_sat = gain_sum[GainW-1:0];
    end
  end

  logic [2*QuotW-1:0] q_sq;
  assign q_sq = quot_q * quot_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept && !in_data_i.stream_end) state_d = ST_DECIDE;
      end
      ST_DECIDE: state_d = timed ? ST_DIV : ST_FINISH;
      ST_DIV: begin
        if (div_rsp.done) state_d = ST_SQR;
      end
      ST_SQR:    state_d = ST_MUL;
      ST_MUL:    state_d = ST_FINISH;
      ST_FINISH: begin
        if (out_free) state_d = ST_IDLE;
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      time_step_q  <= TIME_STEP_RESET;
      phase_time_q <= '0;
      prev_gate_q  <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) time_step_q <= cfg_wdata_i;
      if (in_accept && !in_data_i.stream_end) prev_gate_q <= in_data_i.gate_on;
      // commit the cleared or advanced time once the phase is known
      if (state_q == ST_DECIDE) phase_time_q <= timed ? t_next : t_q;
      if (state_q == ST_FINISH && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      gate_q <= in_data_i.gate_on;
      a_q    <= in_data_i.attack_time;
      d_q    <= in_data_i.decay_time;
      r_q    <= in_data_i.release_time;
      s_q    <= in_data_i.sustain_level;
      // a gate edge restarts the phase clock
      t_q    <= (in_data_i.gate_on != prev_gate_q) ? '0 : phase_time_q;
    end
    if (state_q == ST_DECIDE) begin
      prod_q <= '0;
      if (in_attack) begin
        // 2q^2 - 1: scale by 2^16 so the common Q30 rounding applies
        phase_q <= PH_ATTACK;
        coef_q  <= CoefW'(65536);
        base_q  <= 16'sh8000;
      end else if (in_decay) begin
        phase_q <= PH_DECAY;
        coef_q  <= CoefW'(32768) - {{(CoefW - GainW){s_q[GainW-1]}}, s_q};
        base_q  <= s_q;
      end else if (in_release) begin
        phase_q <= PH_RELEASE;
        coef_q  <= CoefW'(32768) + {{(CoefW - GainW){s_q[GainW-1]}}, s_q};
        base_q  <= 16'sh8000;
      end else if (gate_q) begin
        phase_q <= PH_SUSTAIN;
        coef_q  <= '0;
        base_q  <= s_q;
      end else begin
        phase_q <= PH_IDLE;
        coef_q  <= '0;
        base_q  <= 16'sh8000;
      end
    end
    if (div_rsp.done) quot_q <= div_rsp.quot;
    if (state_q == ST_SQR) sq_q <= q_sq[SqW-1:0];
    if (state_q == ST_MUL) prod_q <= coef_q * sq_q;
    if (state_q == ST_FINISH && out_free) begin
      out_data_q.gain  <= gain_sat;
      out_data_q.phase <= phase_q;
    end
  end

  // the divider reports only while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> state_q == ST_DIV)
    else $error("divider result outside the divide state");

  // a sample with a result always enters phase selection next
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && !in_data_i.stream_end |=> state_q == ST_DECIDE)
    else $error("accepted sample did not start");

  // a finished result with a free slot shows up at the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FINISH && out_free |=> out_valid_o)
    else $error("finished result not presented");

  // phase codes stay within the defined set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.phase <= PH_IDLE)
    else $error("bad phase code at output");

endmodule

@@ tb/tb_adsr_envelope_generator_unit.sv @@
`timescale 1ns / 100ps

module tb_adsr_envelope_generator_unit;
  import adsr_pkg::*;

  // Budget for the whole run; the slowest legal run stays well below this.
  localparam int CYCLE_LIMIT = 2_500_000;
  // Cycles to hold after the last result before touching the step register;
  // a margin only, since an accepted stream_end transaction leaves nothing
  // in flight.
  localparam int SETTLE_CYCLES = 40;
  localparam int LONG_SAMPLES = 100;

  // Shadow envelope: holds its own phase time, last gate and step, and
  // queues the gain/phase that each accepted non-stream_end sample must produce.
  class envelope_scoreboard;
    logic [StepW-1:0] step;
    logic [TimeW-1:0] elapsed;
    logic             held_gate;
    adsr_out_t        expected_gain_q[$];
    int               mismatches;

    function new();
      step       = TIME_STEP_RESET;
      elapsed    = '0;
      held_gate  = 1'b0;
      mismatches = 0;
    endfunction

    function longint unsigned ratio_q15(longint unsigned num, longint unsigned den);
      if (den == 0) return 0;
      return (num << 15) / den;
    endfunction

    // Advance phase time by one step, pinned at all ones.
    function void advance();
      longint unsigned sum;
      sum = 64'(elapsed);
      sum += 64'(step);
      elapsed = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
    endfunction

    function void note_sample(adsr_in_t x);
      longint unsigned a, d, r, t, ad, q, sq, w;
      longint          s, g;
      logic [2:0]      ph;
      adsr_out_t       res;
      if (x.stream_end) return;
      if (x.gate_on != held_gate) elapsed = '0;
      t  = 64'(elapsed);
      a  = 64'(x.attack_time);
      d  = 64'(x.decay_time);
      r  = 64'(x.release_time);
      s  = longint'($signed(x.sustain_level));
      ad = a + d;
      if (x.gate_on) begin
        if (a != 0 && t <= a) begin
          q  = ratio_q15(t, a);
          sq = q * q;
          g  = longint'((sq + 64'd8192) >> 14) - 32768;
          ph = PH_ATTACK;
          advance();
        end else if (d != 0 && t <= ad) begin
          q  = ratio_q15(ad - t, d);
          sq = q * q;
          w  = 32768 - s;
          g  = s + longint'((w * sq + 64'd536870912) >> 30);
          ph = PH_DECAY;
          advance();
        end else begin
          g  = s;
          ph = PH_SUSTAIN;
        end
      end else begin
        if (r != 0 && t <= r) begin
          q  = ratio_q15(r - t, r);
          sq = q * q;
          w  = 32768 + s;
          g  = longint'((w * sq + 64'd536870912) >> 30) - 32768;
          ph = PH_RELEASE;
          advance();
        end else begin
          g  = -32768;
          ph = PH_IDLE;
        end
      end
      held_gate = x.gate_on;
      if (g > 32767) g = 32767;
      if (g < -32768) g = -32768;
      res.gain  = g[15:0];
      res.phase = ph;
      expected_gain_q.push_back(res);
    endfunction

    function void check_result(adsr_out_t got);
      adsr_out_t want;
      if (expected_gain_q.size() == 0) begin
        $display("%0t: result with nothing pending: expected none, got gain %0d phase %0d",
                 $time, $signed(got.gain), got.phase);
        mismatches++;
        return;
      end
      want = expected_gain_q.pop_front();
      if (got.gain !== want.gain) begin
        $display("%0t: gain mismatch: expected %0d, got %0d",
                 $time, $signed(want.gain), $signed(got.gain));
        mismatches++;
      end
      if (got.phase !== want.phase) begin
        $display("%0t: phase mismatch: expected %0d, got %0d",
                 $time, want.phase, got.phase);
        mismatches++;
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  adsr_in_t         in_data = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  adsr_out_t        out_data;
  logic             cfg_we = 1'b0;
  logic [StepW-1:0] cfg_wdata = '0;

  bit send_quiet = 1'b0;   // no sender gaps
  bit recv_quiet = 1'b0;   // no receiver stalls
  int stall_left = 0;
  int stall_pick;
  int cycle_count = 0;

  envelope_scoreboard sb = new();

  adsr_envelope_generator_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Watchdog: end the run if the block hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Sample both channels at the rising edge. Check the output first; its
  // expectation was queued by an earlier input transaction.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_result(out_data);
      if (in_valid && !in_stall) sb.note_sample(in_data);
    end
  end

  // Receiver back-pressure: mostly short bursts, now and then a long stall.
  always @(negedge clk) begin
    if (!rst_n || recv_quiet) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
    end else begin
      stall_pick = $urandom_range(0, 99);
      if (stall_pick < 55) begin
        out_stall <= 1'b0;
        stall_left = $urandom_range(0, 6);
      end else if (stall_pick < 93) begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(0, 2);
      end else begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(10, 40);
      end
    end
  end

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 65) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic adsr_in_t sample_of(input logic gate, input logic [31:0] a,
                                         input logic [31:0] d, input logic [15:0] s,
                                         input logic [31:0] r, input logic fin);
    adsr_in_t x;
    x.gate_on       = gate;
    x.attack_time   = a;
    x.decay_time    = d;
    x.sustain_level = s;
    x.release_time  = r;
    x.stream_end    = fin;
    return x;
  endfunction

  // Pick a phase length in units of the current step so that a note walks
  // through all of its phases in a few dozen samples; some are extremes.
  function automatic logic [31:0] rand_dur(input logic [StepW-1:0] step);
    int unsigned unit;
    unit = (step == 0) ? 1486 : step;
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return $urandom;
      2: return 32'hFFFF_FFFF;
      3: return unit * $urandom_range(1, 12);
      default: return unit * $urandom_range(0, 12) + $urandom_range(0, unit);
    endcase
  endfunction

  // Drive one transaction. Enter and leave at a falling edge; valid stays
  // high between back-to-back transactions and drops only for a gap.
  task automatic send_sample(input adsr_in_t x);
    int gap;
    gap = send_quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= x;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Drop valid and hold until every queued result has come out.
  task automatic pause_until_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.expected_gain_q.size() != 0);
  endtask

  // Write the step register with the block idle, then track it in the model.
  task automatic write_step(input logic [StepW-1:0] v);
    pause_until_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    sb.step = v;
  endtask

  // Play well-formed notes (gate on, then off) with random shape, salted
  // with stray samples, gate glitches and stream_end transactions.
  task automatic play_notes(input int target, input logic [StepW-1:0] step);
    adsr_in_t note, y;
    int       sent, on_len, off_len, i;
    sent = 0;
    while (sent < target) begin
      note.attack_time   = rand_dur(step);
      note.decay_time    = rand_dur(step);
      note.sustain_level = 16'($urandom);
      note.release_time  = rand_dur(step);
      on_len  = $urandom_range(1, 40);
      off_len = $urandom_range(1, 30);
      if ($urandom_range(0, 19) == 0) pause_until_drained();
      for (i = 0; i < on_len + off_len; i++) begin
        note.gate_on    = (i < on_len);
        note.stream_end = ($urandom_range(0, 19) == 0);
        y = note;
        if ($urandom_range(0, 14) == 0) begin
          y.gate_on       = 1'($urandom);
          y.attack_time   = $urandom;
          y.decay_time    = $urandom;
          y.sustain_level = 16'($urandom);
          y.release_time  = $urandom;
        end
        send_sample(y);
        if (!y.stream_end) sent++;
      end
    end
  endtask

  initial begin
    int i;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: zero-length phases, end points, clamping, stream_end keeping
    // the last gate, full-scale fields. Step is the reset value here.
    send_sample(sample_of(1'b0, 0, 0, 16'd0, 0, 1'b0));
    send_sample(sample_of(1'b1, 0, 0, 16'h7FFF, 0, 1'b0));
    send_sample(sample_of(1'b1, 0, 0, 16'h8000, 0, 1'b0));
    send_sample(sample_of(1'b0, 0, 0, 16'd0, 0, 1'b1));
    // Attack of two steps: start, middle, end point (clamps), decay end, sustain.
    repeat (5) send_sample(sample_of(1'b1, 2972, 1486, 16'd0, 0, 1'b0));
    send_sample(sample_of(1'b0, 0, 0, 16'h7FFF, 32'hFFFF_FFFF, 1'b0));
    send_sample(sample_of(1'b0, 0, 0, 16'h8000, 1486, 1'b0));
    send_sample(sample_of(1'b0, 0, 0, 16'h8000, 1486, 1'b0));
    send_sample(sample_of(1'b1, '1, '1, 16'hFFFF, '1, 1'b1));
    send_sample(sample_of(1'b1, '1, '1, 16'hFFFF, '1, 1'b0));
    send_sample(sample_of(1'b1, 0, '1, 16'h8000, 0, 1'b0));
    send_sample(sample_of(1'b1, 0, 0, 16'd12345, 0, 1'b0));
    send_sample(sample_of(1'b0, 0, 0, 16'd0, 0, 1'b0));
    send_sample(sample_of(1'b0, 0, 0, 16'd0, 2000, 1'b0));
    repeat (3) send_sample(sample_of(1'b1, 1486, 0, 16'd16384, 1486, 1'b0));
    send_sample(sample_of(1'b1, 0, 3000, -16'sd20000, 0, 1'b0));

    // Random notes under several step settings, extremes included.
    play_notes(210, TIME_STEP_RESET);
    write_step(20'd1);
    play_notes(180, 20'd1);
    write_step(20'd655360);
    play_notes(180, 20'd655360);
    write_step(20'd0);
    play_notes(130, 20'd0);
    write_step(20'hFFFFF);
    play_notes(180, 20'hFFFFF);
    begin
      logic [StepW-1:0] mid_step;
      mid_step = StepW'($urandom_range(1, 655360));
      write_step(mid_step);
      play_notes(180, mid_step);
    end
    // A stretch with no sender gaps and no receiver stalls.
    write_step(TIME_STEP_RESET);
    send_quiet = 1'b1;
    recv_quiet = 1'b1;
    play_notes(120, TIME_STEP_RESET);

    // Long note with the largest step: phase time crosses the attack end and
    // enters a decay whose end lies past 32 bits.
    write_step(20'hFFFFF);
    recv_quiet = 1'b0;
    send_sample(sample_of(1'b0, 0, 0, 16'd0, 0, 1'b0));
    for (i = 0; i < LONG_SAMPLES; i++) begin
      send_sample(sample_of(1'b1, 32'h0400_0000, 32'hFFFF_FFFF, 16'($urandom), $urandom,
                            1'b0));
    end
    send_quiet = 1'b0;

    pause_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
